@@ rtl/ist_pkg.sv @@
package ist_pkg;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 7;

    // operation codes carried on s_op
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_we;   // write an empty slot at the sweep address
        logic start;    // latch the input word, rewind the search
        logic scan_en;  // read the slot at the sweep address, advance
        logic commit;   // apply the update, load the result register
    } ist_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic addr_last; // sweep address is at the last slot
    } ist_stat_t;

endpackage

@@ rtl/integer_set_table_unit.sv @@
// Channel  Handshake           Word
// -------  ------------------  ----------------------------------------
// input    s_valid / s_ready   s_op, s_value
// result   m_valid / m_ready   m_ok, m_full_res, m_size, m_empty_res
//
// Each word passes through accept, one slot-memory read per slot, a drain
// step for the last compare, then the write-back and result load.
// After reset a clearing sweep empties the slot memory;
// s_ready stays low until it ends.
// A result waits in its register; the next word is accepted meanwhile and
// its write-back holds until the previous result has been taken.
module integer_set_table_unit #(
    parameter int SLOTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ist_pkg::OP_W-1:0]         s_op,
    input  logic signed [ist_pkg::VAL_W-1:0] s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_ok,
    output logic                             m_full_res,
    output logic [ist_pkg::SIZE_W-1:0]       m_size,
    output logic                             m_empty_res
);
    import ist_pkg::*;

    ist_cmd_t  cmd;
    ist_stat_t stat;

    // sequence the sweep, search and update
    ist_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // slot memory, search and result registers
    ist_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_op        (s_op),
        .s_value     (s_value),
        .m_ok        (m_ok),
        .m_full_res  (m_full_res),
        .m_size      (m_size),
        .m_empty_res (m_empty_res)
    );

endmodule

@@ rtl/ist_ctrl.sv @@
module ist_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ist_pkg::ist_cmd_t cmd,
    input  ist_pkg::ist_stat_t stat
);
    import ist_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   commit;

    // result register is free when empty or being taken this cycle
    assign commit  = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // decode commands from state
    always_comb begin
        cmd         = '0;
        cmd.clr_we  = (state_reg == ST_CLEAR);
        cmd.start   = (state_reg == ST_IDLE) && s_valid;
        cmd.scan_en = (state_reg == ST_SCAN);
        cmd.commit  = commit;
    end

    // sequence: clearing sweep, then accept, scan, drain, update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (stat.addr_last) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (stat.addr_last) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (commit) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

endmodule

@@ rtl/ist_dpath.sv @@
module ist_dpath #(
    parameter int SLOTS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ist_pkg::ist_cmd_t            cmd,
    output ist_pkg::ist_stat_t           stat,
    input  logic [ist_pkg::OP_W-1:0]     s_op,
    input  logic signed [ist_pkg::VAL_W-1:0] s_value,
    output logic                         m_ok,
    output logic                         m_full_res,
    output logic [ist_pkg::SIZE_W-1:0]   m_size,
    output logic                         m_empty_res
);
    import ist_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic             vld;
        logic [VAL_W-1:0] val;
    } slot_t;

    slot_t slot_mem [SLOTS];

    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic             rd_vld_reg;
    slot_t            rd_data_reg;
    logic [OP_W-1:0]  op_reg;
    logic [VAL_W-1:0] value_reg;
    logic             hit_reg;
    logic [AW-1:0]    hit_idx_reg;
    logic             free_reg;
    logic [AW-1:0]    free_idx_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             ok_reg;
    logic             full_reg;
    logic [SIZE_W-1:0] size_reg;
    logic             empty_reg;

    logic             addr_last;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    slot_t            wr_data;
    logic             do_add;
    logic             do_remove;
    logic             res_ok;
    logic             res_full;
    logic [CW+SIZE_W-1:0] size_ext;

    assign addr_last      = (addr_reg == AW'(SLOTS - 1));
    assign stat.addr_last = addr_last;

    // decide the update from the search outcome
    assign do_add    = (op_reg == OP_ADD) && !hit_reg && free_reg;
    assign do_remove = (op_reg == OP_REMOVE) && hit_reg;
    assign res_full  = (op_reg == OP_ADD) && !hit_reg && !free_reg;
    assign res_ok    = do_add || do_remove || ((op_reg == OP_TEST) && hit_reg);

    always_comb begin
        count_next = count_reg;
        if (do_add) begin
            count_next = count_reg + CW'(1);
        end else if (do_remove) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign size_ext = {{SIZE_W{1'b0}}, count_next};

    // single write port: clearing sweep or commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (cmd.clr_we) begin
            wr_en = 1'b1;
        end else if (cmd.commit && do_add) begin
            wr_en       = 1'b1;
            wr_addr     = free_idx_reg;
            wr_data.vld = 1'b1;
            wr_data.val = value_reg;
        end else if (cmd.commit && do_remove) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    // sweep address and read-valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_en;
            if (cmd.clr_we || cmd.scan_en) begin
                addr_reg <= addr_last ? '0 : addr_reg + AW'(1);
            end
        end
    end

    // hold the input word, collect match and first free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (cmd.start) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (rd_data_reg.vld && (rd_data_reg.val == value_reg)) begin
                hit_reg <= 1'b1;
            end
            if (!rd_data_reg.vld && !free_reg) begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= s_op;
            value_reg <= s_value;
        end
        if (rd_vld_reg && rd_data_reg.vld && (rd_data_reg.val == value_reg)) begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (rd_vld_reg && !rd_data_reg.vld && !free_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // element count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            ok_reg    <= res_ok;
            full_reg  <= res_full;
            size_reg  <= size_ext[SIZE_W-1:0];
            empty_reg <= (count_next == '0);
        end
    end

    assign m_ok        = ok_reg;
    assign m_full_res  = full_reg;
    assign m_size      = size_reg;
    assign m_empty_res = empty_reg;

endmodule
